/* design/jsd_pkg.sv */
package jsd_pkg;

    localparam int unsigned AXIS_W = 16;
    localparam int unsigned MAG_W  = 16;
    localparam int unsigned SQ_W   = 32;
    localparam int unsigned RAD_W  = 16;
    localparam int unsigned PROD_W = 32;
    localparam logic [SQ_W-1:0]  SQ_THRESH   = 32'd107374;
    localparam logic [MAG_W-1:0] AXIS_THRESH = 16'd328;

    // Sideband carried with each item through the pipeline.
    typedef struct packed {
        logic signed [AXIS_W-1:0] raw_x;
        logic signed [AXIS_W-1:0] raw_y;
        logic [MAG_W-1:0]         mag_x;
        logic [MAG_W-1:0]         mag_y;
        logic [MAG_W-1:0]         mag_max;
        logic                     map_en;
    } t_side;

endpackage

/* design/jsd_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module jsd_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [jsd_pkg::SQ_W-1:0] i_sq,
    input  jsd_pkg::t_side           i_side,
    output logic                     o_valid,
    output logic [jsd_pkg::RAD_W-1:0] o_root,
    output jsd_pkg::t_side           o_side
);
    import jsd_pkg::*;

    localparam int unsigned N = RAD_W;

    logic           r_v    [N];
    logic [SQ_W-1:0] r_rem [N];
    logic [RAD_W-1:0] r_root [N];
    t_side          r_side [N];

    logic [SQ_W-1:0]  n_rem  [N];
    logic [RAD_W-1:0] n_root [N];

    // Stage k decides bit (N-1-k) of the root.
    always_comb begin
        logic [SQ_W-1:0]  rem_in;
        logic [RAD_W-1:0] root_in;
        logic [SQ_W+1:0]  trial;
        logic [SQ_W+1:0]  cur;
        for (int k = 0; k < N; k++) begin
            rem_in  = (k == 0) ? i_sq : r_rem[k-1];
            root_in = (k == 0) ? '0 : r_root[k-1];
            // Trial subtrahend: (root << (bitpos + 1)) + (1 << 2*bitpos), where root
            // holds the bits decided so far at their final positions.
            trial = ({{(SQ_W+2-RAD_W){1'b0}}, root_in} << (N - k))
                  | ({{(SQ_W+1){1'b0}}, 1'b1} << (2 * (N - 1 - k)));
            cur = {2'b00, rem_in};
            if (cur >= trial) begin
                n_rem[k]  = SQ_W'(cur - trial);
                n_root[k] = root_in | (RAD_W'(1) << (N - 1 - k));
            end else begin
                n_rem[k]  = rem_in;
                n_root[k] = root_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < N; k++) r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

/* design/jsd_div.sv */
// Pipelined restoring divider for both axes in parallel, one quotient bit per stage.
module jsd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [jsd_pkg::RAD_W-1:0]  i_root,
    input  jsd_pkg::t_side             i_side,
    output logic                       o_valid,
    output logic signed [jsd_pkg::AXIS_W-1:0] o_disc_x,
    output logic signed [jsd_pkg::AXIS_W-1:0] o_disc_y,
    output logic [jsd_pkg::RAD_W-1:0]  o_radius
);
    import jsd_pkg::*;

    localparam int unsigned N = PROD_W;

    // Product stage.
    logic             r_pv;
    logic [PROD_W-1:0] r_px, r_py;
    logic [RAD_W-1:0] r_pr;
    t_side            r_ps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv <= 1'b0;
        else if (i_en) r_pv <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= i_side.mag_x * i_side.mag_max;
            r_py <= i_side.mag_y * i_side.mag_max;
            r_pr <= i_root;
            r_ps <= i_side;
        end
    end

    logic              r_v  [N];
    logic [PROD_W-1:0] r_qx [N];
    logic [PROD_W-1:0] r_qy [N];
    logic [RAD_W:0]    r_rx [N];
    logic [RAD_W:0]    r_ry [N];
    logic [RAD_W-1:0]  r_d  [N];
    t_side             r_s  [N];

    logic [PROD_W-1:0] n_qx [N];
    logic [PROD_W-1:0] n_qy [N];
    logic [RAD_W:0]    n_rx [N];
    logic [RAD_W:0]    n_ry [N];

    // Quotient register shifts dividend bits out at the top and quotient bits in at the bottom.
    always_comb begin
        logic [PROD_W-1:0] qx, qy;
        logic [RAD_W:0]    rx, ry;
        logic [RAD_W:0]    tx, ty;
        logic [RAD_W-1:0]  d;
        for (int k = 0; k < N; k++) begin
            qx = (k == 0) ? r_px : r_qx[k-1];
            qy = (k == 0) ? r_py : r_qy[k-1];
            rx = (k == 0) ? '0 : r_rx[k-1];
            ry = (k == 0) ? '0 : r_ry[k-1];
            d  = (k == 0) ? r_pr : r_d[k-1];
            tx = {rx[RAD_W-1:0], qx[PROD_W-1]};
            ty = {ry[RAD_W-1:0], qy[PROD_W-1]};
            if (tx >= {1'b0, d}) begin
                n_rx[k] = tx - {1'b0, d};
                n_qx[k] = {qx[PROD_W-2:0], 1'b1};
            end else begin
                n_rx[k] = tx;
                n_qx[k] = {qx[PROD_W-2:0], 1'b0};
            end
            if (ty >= {1'b0, d}) begin
                n_ry[k] = ty - {1'b0, d};
                n_qy[k] = {qy[PROD_W-2:0], 1'b1};
            end else begin
                n_ry[k] = ty;
                n_qy[k] = {qy[PROD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k < N; k++) r_v[k] <= (k == 0) ? r_pv : r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_qx[k] <= n_qx[k];
                r_qy[k] <= n_qy[k];
                r_rx[k] <= n_rx[k];
                r_ry[k] <= n_ry[k];
                r_d[k]  <= (k == 0) ? r_pr : r_d[k-1];
                r_s[k]  <= (k == 0) ? r_ps : r_s[k-1];
            end
        end
    end

    // Sign restore and pass-through select.
    logic [AXIS_W-1:0] w_mx, w_my;
    t_side             w_s;
    assign w_s  = r_s[N-1];
    assign w_mx = r_qx[N-1][AXIS_W-1:0];
    assign w_my = r_qy[N-1][AXIS_W-1:0];

    assign o_valid  = r_v[N-1];
    assign o_radius = r_d[N-1];
    assign o_disc_x = !w_s.map_en ? w_s.raw_x
                    : (w_s.raw_x[AXIS_W-1] ? AXIS_W'(-w_mx) : w_mx);
    assign o_disc_y = !w_s.map_en ? w_s.raw_y
                    : (w_s.raw_y[AXIS_W-1] ? AXIS_W'(-w_my) : w_my);

endmodule

/* design/joystick_square_to_disc.sv */
// Pipeline: 2 front stages, 16 square root stages, 1 product stage,
// 32 divider stages and 1 output register.
// Throughput: one item per cycle; every stage is its own register, so the
// input is taken each cycle unless the output register holds an untaken result.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers are not reset.
module joystick_square_to_disc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] raw_x, [31:16] raw_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // [15:0] disc_x, [31:16] disc_y, [47:32] radius
);
    import jsd_pkg::*;

    // The whole pipe advances together whenever the output register is free
    // or being emptied in this cycle; a stall freezes every stage in place.
    logic w_en;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    logic signed [AXIS_W-1:0] w_x, w_y;
    assign w_x = s_axis_tdata[15:0];
    assign w_y = s_axis_tdata[31:16];

    // Stage 1: magnitudes and squares. A 16-bit two's complement magnitude fits
    // 16 unsigned bits, since |-32768| is 32768.
    logic              r_v1;
    logic [MAG_W-1:0]  r_ax, r_ay;
    logic [SQ_W-1:0]   r_sx, r_sy;
    logic [AXIS_W-1:0] r_x1, r_y1;
    logic [MAG_W-1:0]  n_ax, n_ay;

    assign n_ax = w_x[AXIS_W-1] ? MAG_W'(-w_x) : MAG_W'(w_x);
    assign n_ay = w_y[AXIS_W-1] ? MAG_W'(-w_y) : MAG_W'(w_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_en) r_v1 <= s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
            r_sx <= n_ax * n_ax;
            r_sy <= n_ay * n_ay;
            r_x1 <= w_x;
            r_y1 <= w_y;
        end
    end

    // Stage 2: sum of squares, largest magnitude and the dead zone decision.
    // The sum is at most 2^31, so 32 bits hold it.
    logic            r_v2;
    logic [SQ_W-1:0] r_sq;
    t_side           r_side2;
    logic [MAG_W-1:0] w_m;
    logic [SQ_W-1:0]  w_sq;

    assign w_m  = (r_ax > r_ay) ? r_ax : r_ay;
    assign w_sq = r_sx + r_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_en) r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq            <= w_sq;
            r_side2.raw_x   <= r_x1;
            r_side2.raw_y   <= r_y1;
            r_side2.mag_x   <= r_ax;
            r_side2.mag_y   <= r_ay;
            r_side2.mag_max <= w_m;
            // Above the threshold the root is at least 327, never zero.
            r_side2.map_en  <= (w_sq > SQ_THRESH) && (w_m >= AXIS_THRESH);
        end
    end

    logic              w_sv;
    logic [RAD_W-1:0]  w_root;
    t_side             w_sside;

    jsd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_sq    (r_sq),
        .i_side  (r_side2),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_side  (w_sside)
    );

    logic                     w_dv;
    logic signed [AXIS_W-1:0] w_dx, w_dy;
    logic [RAD_W-1:0]         w_rad;

    jsd_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_sv),
        .i_root   (w_root),
        .i_side   (w_sside),
        .o_valid  (w_dv),
        .o_disc_x (w_dx),
        .o_disc_y (w_dy),
        .o_radius (w_rad)
    );

    // Output register.
    logic        r_ov;
    logic [47:0] r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= w_dv;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_od <= {w_rad, w_dy, w_dx};
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

endmodule
